// ===== sv/assert_macros.svh =====
// Assertion macros shared by the odometry RTL.
// Depends on nothing; SYNTH removes the bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== sv/ddoh_pkg.sv =====
// Types, constants and the arctangent table for the odometry block.
// Used by every module of the block.
`default_nettype none
package ddoh_pkg;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_MPP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b1;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] heading;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic cordic_init;
    logic cordic_half;
    logic cordic_step;
    logic cordic_end;
    logic mul_x;
    logic mul_y;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_step;
  } status_t;

  function automatic logic signed [33:0] atan_at(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== sv/ddoh_ctrl.sv =====
// Sequencer for the odometry block: load, two CORDIC passes, multiplies.
// Depends on ddoh_pkg.
`default_nettype none
module ddoh_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire ddoh_pkg::status_t status,
  output ddoh_pkg::cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_ITER, S_FULL_END, S_MULX, S_MULY, S_HALF_END, S_OUT
  } state_t;
  state_t state;
  logic second;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.cordic_init = (state == S_INIT);
    cmd.cordic_half = second;
    cmd.cordic_step = (state == S_ITER);
    cmd.cordic_end = (state == S_FULL_END) || (state == S_HALF_END);
    cmd.mul_x = (state == S_MULX);
    cmd.mul_y = (state == S_MULY);
    cmd.commit = (state == S_HALF_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      second <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          state <= S_INIT;
          second <= 1'b0;
        end
        S_INIT: state <= S_ITER;
        S_ITER: if (status.last_step) state <= second ? S_HALF_END : S_FULL_END;
        S_FULL_END: state <= S_MULX;
        S_MULX: state <= S_MULY;
        S_MULY: begin
          state <= S_INIT;
          second <= 1'b1;
        end
        S_HALF_END: state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/ddoh_dp.sv =====
// Datapath: wheel deltas, shared CORDIC, step multiplies and accumulators.
// Depends on ddoh_pkg.
`default_nettype none
module ddoh_dp #(
  parameter int COUNT_WIDTH = ddoh_pkg::COUNT_WIDTH_DEF,
  parameter int CORDIC_STEPS = ddoh_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire ddoh_pkg::cmd_t cmd,
  output ddoh_pkg::status_t status,
  input  wire ddoh_pkg::in_beat_t in_data,
  input  wire logic cfg_we,
  input  wire logic [ddoh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ddoh_pkg::CFG_DATA_W-1:0] cfg_data,
  output ddoh_pkg::out_beat_t out_data
);
  localparam int SW = $clog2(CORDIC_STEPS);

  logic [23:0] mpp;
  logic [15:0] limit;
  logic [COUNT_WIDTH-1:0] left_prev, right_prev, left_cur, right_cur;
  logic signed [15:0] heading;
  logic signed [31:0] acc_x, acc_y;
  logic signed [31:0] res_x, res_y;
  logic signed [33:0] len;
  logic signed [33:0] cx, cy, cz;
  logic flip;
  logic [SW-1:0] step;
  logic signed [33:0] cos_f, sin_f;
  logic signed [15:0] qz, qw;

  function automatic logic signed [COUNT_WIDTH:0] wheel(
    input logic [COUNT_WIDTH-1:0] now, input logic [COUNT_WIDTH-1:0] prev,
    input logic [15:0] lim);
    logic signed [COUNT_WIDTH:0] s;
    logic [COUNT_WIDTH:0] mag;
    s = COUNT_WIDTH'(now - prev);
    s = {s[COUNT_WIDTH-1], s[COUNT_WIDTH-1:0]};
    mag = s[COUNT_WIDTH] ? (COUNT_WIDTH+1)'(-s) : s;
    if (mag != 0 && mag < (COUNT_WIDTH+1)'(lim)) return s;
    return '0;
  endfunction

  function automatic logic signed [33:0] clip1(input logic signed [33:0] v);
    if (v > ddoh_pkg::ONE_Q30) return ddoh_pkg::ONE_Q30;
    if (v < -ddoh_pkg::ONE_Q30) return -ddoh_pkg::ONE_Q30;
    return v;
  endfunction

  function automatic logic signed [15:0] quat(input logic signed [33:0] v);
    logic signed [33:0] a, r;
    a = v[33] ? -v : v;
    r = (a + 34'sd16384) >>> 15;
    if (v[33]) r = -r;
    if (r > 34'sd32767) return 16'sh7fff;
    return r[15:0];
  endfunction

  logic signed [COUNT_WIDTH+1:0] dsum;
  logic signed [COUNT_WIDTH+26:0] lprod;
  logic signed [COUNT_WIDTH+26:0] lmag;
  logic signed [33:0] lround;
  always_comb begin
    dsum = (COUNT_WIDTH+2)'(wheel(in_data.left_count[COUNT_WIDTH-1:0], left_prev, limit))
         + (COUNT_WIDTH+2)'(wheel(in_data.right_count[COUNT_WIDTH-1:0], right_prev, limit));
    lprod = (COUNT_WIDTH+27)'(dsum) * $signed({1'b0, mpp});
    lmag = lprod[COUNT_WIDTH+26] ? -lprod : lprod;
    lmag = (lmag + 256) >>> 9;
    lround = lprod[COUNT_WIDTH+26] ? -34'(lmag) : 34'(lmag);
  end

  logic signed [33:0] z0;
  logic signed [34:0] zs;
  always_comb begin
    zs = cmd.cordic_half ? 35'(heading) <<< 15 : 35'(heading) <<< 16;
    flip = 1'b0;
    z0 = 34'(zs);
    if (zs > 35'sd1073741824) begin
      z0 = 34'(zs - 35'sd2147483648);
      flip = 1'b1;
    end else if (zs < -35'sd1073741824) begin
      z0 = 34'(zs + 35'sd2147483648);
      flip = 1'b1;
    end
  end

  logic flip_r;
  logic signed [33:0] xs, ys, ang;
  always_comb begin
    xs = cx >>> step;
    ys = cy >>> step;
    ang = ddoh_pkg::atan_at(5'(step));
  end
  assign status.last_step = (step == SW'(CORDIC_STEPS - 1));

  logic signed [67:0] mprod;
  logic signed [67:0] mmag;
  logic signed [33:0] mstep;
  logic signed [34:0] nsum;
  always_comb begin
    mprod = 68'(len) * 68'(cmd.mul_x ? cos_f : sin_f);
    mmag = mprod[67] ? -mprod : mprod;
    mmag = (mmag + 68'sd536870912) >>> 30;
    mstep = mprod[67] ? -34'(mmag) : 34'(mmag);
    nsum = 35'(cmd.mul_x ? acc_x : acc_y) + 35'(mstep);
  end

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    if (v < -35'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mpp <= '0;
      limit <= 16'd15000;
      left_prev <= '0;
      right_prev <= '0;
      acc_x <= '0;
      acc_y <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ddoh_pkg::REG_MPP: mpp <= cfg_data;
          ddoh_pkg::REG_LIMIT: limit <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        left_prev <= in_data.left_count[COUNT_WIDTH-1:0];
        right_prev <= in_data.right_count[COUNT_WIDTH-1:0];
      end
      if (cmd.mul_x) acc_x <= sat32(nsum);
      if (cmd.mul_y) acc_y <= sat32(nsum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      heading <= in_data.heading;
      len <= lround;
    end
    if (cmd.cordic_init) begin
      cx <= ddoh_pkg::GAIN_Q30;
      cy <= '0;
      cz <= z0;
      flip_r <= flip;
      step <= '0;
    end
    if (cmd.cordic_step) begin
      if (!cz[33]) begin
        cx <= cx - ys; cy <= cy + xs; cz <= cz - ang;
      end else begin
        cx <= cx + ys; cy <= cy - xs; cz <= cz + ang;
      end
      step <= step + 1'b1;
    end
    if (cmd.cordic_end) begin
      cos_f <= clip1(flip_r ? -cx : cx);
      sin_f <= clip1(flip_r ? -cy : cy);
    end
  end

  always_comb begin
    qz = quat(sin_f);
    qw = quat(cos_f);
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_x <= acc_x;
      res_y <= acc_y;
    end
  end
  assign out_data = '{pos_x: res_x, pos_y: res_y, quat_z: qz, quat_w: qw};
endmodule
`default_nettype wire

// ===== sv/diff_drive_odometry_heading.sv =====
// Top level of the differential drive odometry block.
// Depends on ddoh_pkg, ddoh_ctrl, ddoh_dp and assert_macros.svh.
//   channel  | signals                     | beat
//   input    | in_valid, in_ready, in_data | encoder counts and heading
//   output   | out_valid, out_ready, out_data | position and quaternion
//   config   | cfg_we, cfg_index, cfg_data | one register write
// From acceptance a beat passes S_INIT, the CORDIC steps, S_FULL_END, S_MULX,
// S_MULY, a second S_INIT and CORDIC pass, and S_HALF_END before out_valid rises.
// The shared iterative CORDIC runs twice per beat.
// Reset is synchronous; it restores register defaults and clears position.
// A stalled result holds the block; no new beat is taken until it leaves.
`default_nettype none
`include "assert_macros.svh"
module diff_drive_odometry_heading #(
  parameter int COUNT_WIDTH = ddoh_pkg::COUNT_WIDTH_DEF,
  parameter int CORDIC_STEPS = ddoh_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire ddoh_pkg::in_beat_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output ddoh_pkg::out_beat_t out_data,
  input  wire logic cfg_we,
  input  wire logic [ddoh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ddoh_pkg::CFG_DATA_W-1:0] cfg_data
);
  ddoh_pkg::cmd_t cmd;
  ddoh_pkg::status_t status;

  ddoh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  ddoh_dp #(.COUNT_WIDTH(COUNT_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_data(out_data)
  );

  `ASSERT_IMPLIES(a_no_overlap, clk, rst, out_valid, !in_ready)
  `ASSERT_NEXT(a_out_after_commit, clk, rst, cmd.commit, out_valid)
  `ASSERT_NEXT(a_load_leaves_idle, clk, rst, in_valid && in_ready, !in_ready)
endmodule
`default_nettype wire
